// ===== rtl/core/gww_pkg.sv =====
// Shared types and constants for the greedy word wrap line breaker.
package gww_pkg;

    localparam int MAX_TEXT_CHARS = 4096;
    localparam int POS_W          = 13;
    localparam int PIX_W          = 20;
    localparam int CODE_W         = 16;
    localparam int CWIDTH_W       = 8;
    localparam int MLW_W          = 16;

    localparam logic [POS_W-1:0] POS_LIMIT =
        POS_W'((MAX_TEXT_CHARS < 8191) ? MAX_TEXT_CHARS : 8191);
    localparam logic [PIX_W-1:0] PIX_MAX = {PIX_W{1'b1}};

    localparam logic [CODE_W-1:0] CODE_SPACE  = 16'h0020;
    localparam logic [CODE_W-1:0] CODE_HYPHEN = 16'h002D;

    // Register byte addresses
    localparam logic [2:0] ADDR_MAX_LINE_WIDTH = 3'd0;

    typedef struct packed {
        logic [CODE_W-1:0]   character;
        logic [CWIDTH_W-1:0] char_width;
        logic                end_of_text;
    } gww_item_t;

    typedef struct packed {
        logic [POS_W-1:0] start_idx;
        logic [POS_W-1:0] stop_idx;
        logic             line_valid;
        logic             last_line;
    } gww_result_t;

    function automatic logic [PIX_W-1:0] sat_add(input logic [PIX_W-1:0] a,
                                                 input logic [CWIDTH_W-1:0] b);
        logic [PIX_W:0] s;
        s = {1'b0, a} + {{(PIX_W+1-CWIDTH_W){1'b0}}, b};
        return s[PIX_W] ? PIX_MAX : s[PIX_W-1:0];
    endfunction

endpackage

// ===== rtl/core/gww_in_reg.sv =====
// Input register stage: holds one request until the breaker takes it.
module gww_in_reg (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  gww_pkg::gww_item_t s_item,
    output logic               q_valid,
    input  logic               q_take,
    output gww_pkg::gww_item_t q_item
);

    logic               valid_reg, valid_next;
    gww_pkg::gww_item_t item_reg;

    assign s_ready    = !valid_reg || q_take;
    assign valid_next = (s_valid && s_ready) ? 1'b1 : (q_take ? 1'b0 : valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

    assign q_valid = valid_reg;
    assign q_item  = item_reg;

endmodule

// ===== rtl/core/gww_core.sv =====
// Line breaking state and result register.
module gww_core (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic [gww_pkg::MLW_W-1:0]        max_line_width,
    input  logic                             in_valid,
    output logic                             in_take,
    input  gww_pkg::gww_item_t               in_item,
    output logic                             res_valid,
    input  logic                             res_ready,
    output gww_pkg::gww_result_t             res
);

    logic [gww_pkg::POS_W-1:0] position_reg, position_next;
    logic                      lead_reg, lead_next;
    logic                      run_reg, run_next;
    logic [gww_pkg::POS_W-1:0] cls_reg, cls_next;
    logic [gww_pkg::POS_W-1:0] bp_reg, bp_next;
    logic [gww_pkg::POS_W-1:0] wb_reg, wb_next;
    logic [gww_pkg::PIX_W-1:0] lp_reg, lp_next;
    logic [gww_pkg::PIX_W-1:0] wp_reg, wp_next;

    logic                      emit;
    gww_pkg::gww_result_t      res_new;
    logic                      res_valid_reg, res_valid_next;
    gww_pkg::gww_result_t      res_reg;

    assign in_take = in_valid && (!res_valid_reg || res_ready);

    always_comb begin
        position_next = position_reg;
        lead_next     = lead_reg;
        run_next      = run_reg;
        cls_next      = cls_reg;
        bp_next       = bp_reg;
        wb_next       = wb_reg;
        lp_next       = lp_reg;
        wp_next       = wp_reg;
        emit          = 1'b0;
        res_new       = '0;

        if (in_item.end_of_text) begin
            emit             = 1'b1;
            res_new.last_line = 1'b1;
            if (!lead_reg && cls_reg != position_reg) begin
                res_new.start_idx  = cls_reg;
                res_new.stop_idx   = position_reg;
                res_new.line_valid = 1'b1;
            end
            position_next = '0;
            lead_next     = 1'b1;
            run_next      = 1'b0;
            cls_next      = '0;
            bp_next       = '0;
            wb_next       = '0;
            lp_next       = '0;
            wp_next       = '0;
        end else if (position_reg >= gww_pkg::POS_LIMIT) begin
            // text too long: drop characters until the terminator
        end else if (lead_reg && in_item.character == gww_pkg::CODE_SPACE) begin
            position_next = position_reg + 1'b1;
        end else begin
            if (lead_reg) begin
                lead_next = 1'b0;
                cls_next  = position_reg;
                bp_next   = position_reg;
                wb_next   = position_reg;
            end
            if (in_item.character == gww_pkg::CODE_SPACE) begin
                if (!run_reg) begin
                    bp_next  = position_reg;
                    run_next = 1'b1;
                end
                lp_next = gww_pkg::sat_add(lp_reg, in_item.char_width);
            end else begin
                if (run_reg) begin
                    wb_next  = position_reg;
                    wp_next  = '0;
                    run_next = 1'b0;
                end
                wp_next = gww_pkg::sat_add(wp_next, in_item.char_width);
                lp_next = gww_pkg::sat_add(lp_reg, in_item.char_width);
                if (lp_next > {{(gww_pkg::PIX_W-gww_pkg::MLW_W){1'b0}}, max_line_width}) begin
                    // line too wide: break at the last break point; with none yet on this line,
                    // split the word here, unless this character alone opens the line
                    if (!(cls_next == bp_next && cls_next == position_reg)) begin
                        if (cls_next == bp_next) begin
                            bp_next = position_reg;
                            wb_next = position_reg;
                            wp_next = {{(gww_pkg::PIX_W-gww_pkg::CWIDTH_W){1'b0}},
                                       in_item.char_width};
                        end
                        emit               = 1'b1;
                        res_new.start_idx  = cls_next;
                        res_new.stop_idx   = bp_next;
                        res_new.line_valid = 1'b1;
                        cls_next           = wb_next;
                        bp_next            = wb_next;
                        lp_next            = wp_next;
                    end
                end
                if (in_item.character == gww_pkg::CODE_HYPHEN) begin
                    bp_next = position_reg + 1'b1;
                    wb_next = position_reg + 1'b1;
                    wp_next = '0;
                end
            end
            position_next = position_reg + 1'b1;
        end
    end

    assign res_valid_next = (in_take && emit) ? 1'b1 :
                            (res_ready ? 1'b0 : res_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            position_reg  <= '0;
            lead_reg      <= 1'b1;
            run_reg       <= 1'b0;
            cls_reg       <= '0;
            bp_reg        <= '0;
            wb_reg        <= '0;
            lp_reg        <= '0;
            wp_reg        <= '0;
            res_valid_reg <= 1'b0;
        end else begin
            res_valid_reg <= res_valid_next;
            if (in_take) begin
                position_reg <= position_next;
                lead_reg     <= lead_next;
                run_reg      <= run_next;
                cls_reg      <= cls_next;
                bp_reg       <= bp_next;
                wb_reg       <= wb_next;
                lp_reg       <= lp_next;
                wp_reg       <= wp_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_take && emit) begin
            res_reg <= res_new;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

// ===== rtl/core/greedy_word_wrap_line_breaker.sv =====
// Greedy word wrap line breaker: top level with register port and streams.
//
//  channel   | dir | handshake          | payload
//  ----------+-----+--------------------+-----------------------------------------
//  s_ input  | in  | s_tvalid/s_tready  | tdata: character, char_width; tlast: end
//  m_ result | out | m_tvalid/m_tready  | tdata: start index, end index; tuser; tlast
//  apb cfg   | in  | psel/penable       | max_line_width at byte addresses 0 to 3
//
// One character per cycle sustained while m_tready allows; a request passes the input
// register, then the breaker state and result register, before its result is valid.
// The cycle is set by the single add, saturate and compare on the line width.
// aresetn (synchronous) clears all line state and sets max_line_width to 320.
// A stalled result holds the breaker; the input register still takes one request.
module greedy_word_wrap_line_breaker (
    input  logic        aclk,
    input  logic        aresetn,
    // APB configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [15:0] character, [23:16] char_width
    input  logic        s_tlast,   // end_of_text
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [12:0] start index, [25:13] end index, rest zero
    output logic        m_tuser,   // line_valid
    output logic        m_tlast    // last_line
);

    logic [gww_pkg::MLW_W-1:0] mlw_reg, mlw_next;
    logic                      cfg_wr;

    gww_pkg::gww_item_t   s_item, q_item;
    logic                 q_valid, q_take;
    gww_pkg::gww_result_t res;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && !paddr[2];
    assign mlw_next = cfg_wr ? pwdata[gww_pkg::MLW_W-1:0] : mlw_reg;
    assign prdata = (paddr == gww_pkg::ADDR_MAX_LINE_WIDTH ||
                     paddr[2] == gww_pkg::ADDR_MAX_LINE_WIDTH[2]) ?
                    {{(32-gww_pkg::MLW_W){1'b0}}, mlw_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mlw_reg <= 16'd320;
        end else begin
            mlw_reg <= mlw_next;
        end
    end

    assign s_item.character   = s_tdata[15:0];
    assign s_item.char_width  = s_tdata[23:16];
    assign s_item.end_of_text = s_tlast;

    gww_in_reg u_in_reg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_tvalid),
        .s_ready (s_tready),
        .s_item  (s_item),
        .q_valid (q_valid),
        .q_take  (q_take),
        .q_item  (q_item)
    );

    gww_core u_core (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .max_line_width (mlw_reg),
        .in_valid       (q_valid),
        .in_take        (q_take),
        .in_item        (q_item),
        .res_valid      (m_tvalid),
        .res_ready      (m_tready),
        .res            (res)
    );

    assign m_tdata = {6'd0, res.stop_idx, res.start_idx};
    assign m_tuser = res.line_valid;
    assign m_tlast = res.last_line;

endmodule
